// ===== hdl/nd_index_ravel_unravel_assert.svh =====
// Assertion macros for the ND index unit.
// Define ASSERT_OFF to compile the checks out.
`ifndef ND_INDEX_RAVEL_UNRAVEL_ASSERT_SVH
`define ND_INDEX_RAVEL_UNRAVEL_ASSERT_SVH

`ifndef ASSERT_OFF

// ante holds this cycle -> cons holds this cycle
`define ND_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// ante holds this cycle -> cons holds next cycle
`define ND_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`else

`define ND_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ND_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/nd_idx_pkg.sv =====
package nd_idx_pkg;

    localparam int MAX_DIMS   = 6;
    localparam int FIELD_DIMS = 6;
    localparam int DIM_LIMIT  = (MAX_DIMS < FIELD_DIMS) ? MAX_DIMS : FIELD_DIMS;

    localparam int DATA_W     = 32;
    localparam int NUM_DIMS_W = 3;
    localparam int DIM_IDX_W  = (FIELD_DIMS > 1) ? $clog2(FIELD_DIMS) : 1;
    localparam int CFG_ADDR_W = $clog2(FIELD_DIMS + 1);
    localparam int BIT_CNT_W  = $clog2(DATA_W);
    localparam int TDATA_W    = (((1 + FIELD_DIMS) * DATA_W + 7) / 8) * 8;

    // register indexes on the config port
    localparam logic [CFG_ADDR_W-1:0] REG_NUM_DIMS = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_STRIDE_0 = CFG_ADDR_W'(1);
    localparam logic [CFG_ADDR_W-1:0] REG_STRIDE_END = CFG_ADDR_W'(FIELD_DIMS);

    // item kinds carried on tuser
    localparam logic KIND_RAVEL   = 1'b0;
    localparam logic KIND_UNRAVEL = 1'b1;

    typedef logic [DATA_W-1:0] word_t;

endpackage

// ===== hdl/nd_index_ravel_unravel.sv =====
// Strided N-dimensional index unit. A ravel item (tuser 0) turns the
// coordinates of the dimensions in use into a flat index, the sum of
// coordinate times stride modulo 2^32; an unravel item (tuser 1) divides the
// flat index by each stride from dimension 0 inward, the remainder passing
// on. Unused dimensions read as zero, a zero stride unravels to all ones and
// passes the index on. One item is in flight at a time and goes through a load
// step and a run for each dimension in use between accept and hand-off: a
// single 33-bit add/subtract unit does one bit of the shift-add multiply or of
// the restoring division per cycle. Write the config registers only while the
// block is idle.
`include "nd_index_ravel_unravel_assert.svh"

module nd_index_ravel_unravel
    import nd_idx_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [DATA_W-1:0]     cfg_wdata,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // in_flat_index, in_coord_0 .. in_coord_5 (lowest bits first)
    input  logic [TDATA_W-1:0]    s_axis_tdata,
    // kind
    input  logic                  s_axis_tuser,

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // out_flat_index, out_coord_0 .. out_coord_5 (lowest bits first)
    output logic [TDATA_W-1:0]    m_axis_tdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_RUN,
        S_OUT
    } state_t;

    localparam logic [BIT_CNT_W-1:0] BIT_LAST = BIT_CNT_W'(DATA_W - 1);

    state_t                  state_reg, state_next;
    logic [NUM_DIMS_W-1:0]   num_dims_reg, num_dims_next;
    word_t                   stride_reg [FIELD_DIMS];
    word_t                   stride_next [FIELD_DIMS];

    logic                    kind_reg, kind_next;
    word_t                   coord_reg [FIELD_DIMS];
    word_t                   coord_next [FIELD_DIMS];
    word_t                   res_coord_reg [FIELD_DIMS];
    word_t                   res_coord_next [FIELD_DIMS];
    word_t                   acc_reg, acc_next;
    word_t                   r_reg, r_next;   // remainder / multiplicand
    word_t                   q_reg, q_next;   // dividend-quotient / multiplier
    logic [DIM_IDX_W-1:0]    dim_reg, dim_next;
    logic [BIT_CNT_W-1:0]    bit_cnt_reg, bit_cnt_next;

    logic [NUM_DIMS_W-1:0]   n_use;
    logic                    dim_last;
    word_t                   stride_sel;
    logic [DATA_W:0]         add_a;
    logic [DATA_W:0]         add_b;
    logic                    add_sub;
    logic [DATA_W+1:0]       add_res;

    assign n_use = (num_dims_reg > NUM_DIMS_W'(DIM_LIMIT)) ? NUM_DIMS_W'(DIM_LIMIT)
                                                          : num_dims_reg;
    assign dim_last   = (dim_reg == DIM_IDX_W'(n_use - NUM_DIMS_W'(1)));
    assign stride_sel = stride_reg[dim_reg];

    // the shared unit: restoring-division trial subtract or multiply accumulate
    assign add_sub = (kind_reg == KIND_UNRAVEL);
    assign add_a   = add_sub ? {r_reg, q_reg[DATA_W-1]} : {1'b0, acc_reg};
    assign add_b   = add_sub ? {1'b0, stride_sel} : {1'b0, r_reg};
    assign add_res = add_sub ? ({1'b0, add_a} - {1'b0, add_b})
                             : ({1'b0, add_a} + {1'b0, add_b});

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = (state_reg == S_OUT);

    always_comb begin
        m_axis_tdata = '0;
        m_axis_tdata[DATA_W-1:0] = acc_reg;
        for (int i = 0; i < FIELD_DIMS; i++) begin
            m_axis_tdata[(i + 1) * DATA_W +: DATA_W] = res_coord_reg[i];
        end
    end

    always_comb begin
        state_next     = state_reg;
        num_dims_next  = num_dims_reg;
        stride_next    = stride_reg;
        kind_next      = kind_reg;
        coord_next     = coord_reg;
        res_coord_next = res_coord_reg;
        acc_next       = acc_reg;
        r_next         = r_reg;
        q_next         = q_reg;
        dim_next       = dim_reg;
        bit_cnt_next   = bit_cnt_reg;

        if (cfg_we) begin
            if (cfg_addr == REG_NUM_DIMS) begin
                num_dims_next = cfg_wdata[NUM_DIMS_W-1:0];
            end else if (cfg_addr >= REG_STRIDE_0 && cfg_addr <= REG_STRIDE_END) begin
                stride_next[DIM_IDX_W'(cfg_addr - REG_STRIDE_0)] = cfg_wdata;
            end
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    kind_next = s_axis_tuser;
                    r_next    = s_axis_tdata[DATA_W-1:0];
                    for (int i = 0; i < FIELD_DIMS; i++) begin
                        coord_next[i]     = s_axis_tdata[(i + 1) * DATA_W +: DATA_W];
                        res_coord_next[i] = '0;
                    end
                    acc_next  = '0;
                    dim_next  = '0;
                    state_next = (n_use == '0) ? S_OUT : S_LOAD;
                end
            end
            S_LOAD: begin
                bit_cnt_next = '0;
                if (kind_reg == KIND_UNRAVEL) begin
                    q_next = r_reg;     // remainder of the outer dimension
                    r_next = '0;
                end else begin
                    q_next = stride_sel;
                    r_next = coord_reg[dim_reg];
                end
                state_next = S_RUN;
            end
            S_RUN: begin
                bit_cnt_next = bit_cnt_reg + BIT_CNT_W'(1);
                if (kind_reg == KIND_UNRAVEL) begin
                    if (!add_res[DATA_W+1]) begin
                        r_next = add_res[DATA_W-1:0];
                        q_next = {q_reg[DATA_W-2:0], 1'b1};
                    end else begin
                        r_next = {r_reg[DATA_W-2:0], q_reg[DATA_W-1]};
                        q_next = {q_reg[DATA_W-2:0], 1'b0};
                    end
                end else begin
                    if (q_reg[0]) begin
                        acc_next = add_res[DATA_W-1:0];
                    end
                    r_next = {r_reg[DATA_W-2:0], 1'b0};
                    q_next = {1'b0, q_reg[DATA_W-1:1]};
                end
                if (bit_cnt_reg == BIT_LAST) begin
                    if (kind_reg == KIND_UNRAVEL) begin
                        res_coord_next[dim_reg] = q_next;
                    end
                    if (dim_last) begin
                        state_next = S_OUT;
                    end else begin
                        dim_next   = dim_reg + DIM_IDX_W'(1);
                        state_next = S_LOAD;
                    end
                end
            end
            S_OUT: begin
                if (m_axis_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            num_dims_reg <= NUM_DIMS_W'(1);
            for (int i = 0; i < FIELD_DIMS; i++) begin
                stride_reg[i] <= DATA_W'(1);
            end
        end else begin
            state_reg    <= state_next;
            num_dims_reg <= num_dims_next;
            stride_reg   <= stride_next;
        end
        kind_reg      <= kind_next;
        coord_reg     <= coord_next;
        res_coord_reg <= res_coord_next;
        acc_reg       <= acc_next;
        r_reg         <= r_next;
        q_reg         <= q_next;
        dim_reg       <= dim_next;
        bit_cnt_reg   <= bit_cnt_next;
    end

    `ND_ASSERT_IMP(a_one_side_busy, aclk, aresetn, m_axis_tvalid, !s_axis_tready)
    `ND_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `ND_ASSERT_NEXT(a_run_ends, aclk, aresetn, state_reg == S_RUN && bit_cnt_reg == BIT_LAST, state_reg != S_RUN)
    `ND_ASSERT_IMP(a_unravel_no_flat, aclk, aresetn, m_axis_tvalid && kind_reg == KIND_UNRAVEL, acc_reg == '0)

endmodule
